@@ hw/rtl/lrupr_pkg.sv @@
`default_nettype none

package lrupr_pkg;

  // fixed widths of the result fields and the configuration register
  localparam int FRAME_IDX_W = 3;
  localparam int FAULT_W     = 16;
  localparam int CFG_W       = 4;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam logic [APB_ADDR_W-1:0] REG_FRAMES_IN_USE = 3'd0;
  localparam logic [CFG_W-1:0]      FRAMES_IN_USE_RST = 4'd8;
  localparam logic [FAULT_W-1:0]    FAULT_MAX         = 16'hFFFF;

  // outcome of the frame search for one reference
  typedef struct packed {
    logic hit;
    logic evict;
  } lrupr_pick_t;

endpackage

`default_nettype wire

@@ hw/rtl/lrupr_select.sv @@
`default_nettype none

module lrupr_select #(
  parameter int NUM_FRAMES = 8,
  parameter int IDX_W      = 3
) (
  input  logic [NUM_FRAMES-1:0]            valid_i,
  input  logic [NUM_FRAMES-1:0]            in_range_i,
  input  logic [NUM_FRAMES-1:0]            match_i,
  input  logic [NUM_FRAMES-1:0][IDX_W-1:0] rank_i,
  output lrupr_pkg::lrupr_pick_t           pick_o,
  output logic [NUM_FRAMES-1:0]            sel_o,
  output logic [IDX_W-1:0]                 idx_o
);
  import lrupr_pkg::*;

  logic [NUM_FRAMES-1:0] hit_vec;
  logic [NUM_FRAMES-1:0] empty_vec;
  logic [NUM_FRAMES-1:0] oldest_vec;
  logic [NUM_FRAMES-1:0] cand;
  logic                  any_hit;
  logic                  any_empty;

  assign hit_vec   = valid_i & in_range_i & match_i;
  assign empty_vec = ~valid_i & in_range_i;
  assign any_hit   = |hit_vec;
  assign any_empty = |empty_vec;

  // a frame is oldest when no frame in range has a higher rank
  always_comb begin
    for (int i = 0; i < NUM_FRAMES; i++) begin
      oldest_vec[i] = in_range_i[i];
      for (int j = 0; j < NUM_FRAMES; j++) begin
        if (in_range_i[j] && (rank_i[j] > rank_i[i])) begin
          oldest_vec[i] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    if (any_hit) begin
      cand = hit_vec;
    end else if (any_empty) begin
      cand = empty_vec;
    end else begin
      cand = oldest_vec;
    end
  end

  // lowest set bit wins
  assign sel_o = cand & (~cand + NUM_FRAMES'(1));

  always_comb begin
    idx_o = '0;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (sel_o[i]) begin
        idx_o = idx_o | IDX_W'(i);
      end
    end
  end

  assign pick_o.hit   = any_hit;
  assign pick_o.evict = !any_hit && !any_empty;

endmodule

`default_nettype wire

@@ hw/rtl/lru_page_replacement_top.sv @@
`default_nettype none

// channel      | direction | signals                                   | handshake
// -------------+-----------+-------------------------------------------+-----------------------
// reference    | in        | page_number_i, last_in_run_i              | start high, busy low
// result       | out       | hit_o, frame_index_o, evicted_valid_o,    | result_valid_o, one
//              |           | evicted_page_o, fault_count_o             | cycle, no back-pressure
// config       | in/out    | psel, penable, pwrite, paddr, pwdata,     | apb, pready tied high
//              |           | prdata, pready                            |
//
// one reference per cycle while busy is low; its result strobe is registered through the input
// register, then the frame search into the result register
// busy is held high by reset and drops once the busy register is clocked out of reset
// the receiver cannot stall, so results never back up and start is honored whenever busy is low
// last_in_run clears valid bits, ranks and fault count after its result is formed

module lru_page_replacement_top #(
  parameter int NUM_FRAMES = 8,
  parameter int PAGE_BITS  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // reference transaction
  input  logic                                start,
  output logic                                busy,
  input  logic [PAGE_BITS-1:0]                page_number_i,
  input  logic                                last_in_run_i,
  // result transaction
  output logic                                result_valid_o,
  output logic                                hit_o,
  output logic [lrupr_pkg::FRAME_IDX_W-1:0]   frame_index_o,
  output logic                                evicted_valid_o,
  output logic [PAGE_BITS-1:0]                evicted_page_o,
  output logic [lrupr_pkg::FAULT_W-1:0]       fault_count_o,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lrupr_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [lrupr_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [lrupr_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                pready
);
  import lrupr_pkg::*;

  // frame index and rank share one width
  localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;

  // configuration
  logic [CFG_W-1:0] frames_in_use_q;

  // input register
  logic                 in_vld_q;
  logic [PAGE_BITS-1:0] page_q;
  logic                 last_q;
  logic                 busy_q;

  // frame state
  logic [PAGE_BITS-1:0]            frame_page_q [NUM_FRAMES];
  logic [NUM_FRAMES-1:0]           valid_q;
  logic [NUM_FRAMES-1:0][IDX_W-1:0] rank_q;
  logic [FAULT_W-1:0]              fault_q;

  // search and update
  logic [NUM_FRAMES-1:0]            in_range;
  logic [NUM_FRAMES-1:0]            match;
  lrupr_pick_t                      pick;
  logic [NUM_FRAMES-1:0]            sel;
  logic [IDX_W-1:0]                 idx;
  logic                             was_valid;
  logic [IDX_W-1:0]                 old_rank;
  logic [PAGE_BITS-1:0]             ev_page;
  logic [NUM_FRAMES-1:0]            valid_d;
  logic [NUM_FRAMES-1:0][IDX_W-1:0] rank_d;
  logic [FAULT_W-1:0]               fault_d;

  // result register
  logic                   res_vld_q;
  logic                   res_hit_q;
  logic [FRAME_IDX_W-1:0] res_idx_q;
  logic                   res_ev_q;
  logic [PAGE_BITS-1:0]   res_ev_page_q;
  logic [FAULT_W-1:0]     res_fault_q;

  // ---------------------------------------------------------------------------
  // apb register file: one register, writes land on the access phase
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_in_use_q <= FRAMES_IN_USE_RST;
    end else if (psel && penable && pwrite && (paddr == REG_FRAMES_IN_USE)) begin
      frames_in_use_q <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_FRAMES_IN_USE) begin
      prdata = APB_DATA_W'(frames_in_use_q);
    end
  end

  // ---------------------------------------------------------------------------
  // input register; busy only covers the reset window
  // ---------------------------------------------------------------------------
  assign busy = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b1;
      in_vld_q <= 1'b0;
    end else begin
      busy_q   <= 1'b0;
      in_vld_q <= start && !busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy_q) begin
      page_q <= page_number_i;
      last_q <= last_in_run_i;
    end
  end

  // ---------------------------------------------------------------------------
  // frame search
  // frame 0 is always managed; a count of zero acts as one and a count above
  // the frame total simply covers every frame
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < NUM_FRAMES; i++) begin
      in_range[i] = (i == 0) || (32'(i) < 32'(frames_in_use_q));
      match[i]    = (frame_page_q[i] == page_q);
    end
  end

  lrupr_select #(
    .NUM_FRAMES (NUM_FRAMES),
    .IDX_W      (IDX_W)
  ) u_select (
    .valid_i    (valid_q),
    .in_range_i (in_range),
    .match_i    (match),
    .rank_i     (rank_q),
    .pick_o     (pick),
    .sel_o      (sel),
    .idx_o      (idx)
  );

  // read out the chosen frame through its one-hot select
  always_comb begin
    was_valid = 1'b0;
    old_rank  = '0;
    ev_page   = '0;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (sel[i]) begin
        was_valid = valid_q[i];
        old_rank  = rank_q[i];
        ev_page   = frame_page_q[i];
      end
    end
  end

  // recency update: chosen frame goes to rank 0, younger valid frames age by
  // one; loading an empty frame ages every valid frame, out-of-range ones too
  always_comb begin
    valid_d = valid_q | sel;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (sel[i]) begin
        rank_d[i] = '0;
      end else if (valid_q[i] && (!was_valid || (rank_q[i] < old_rank))) begin
        rank_d[i] = rank_q[i] + IDX_W'(1);
      end else begin
        rank_d[i] = rank_q[i];
      end
    end
  end

  // fault count saturates at its top
  always_comb begin
    fault_d = fault_q;
    if (!pick.hit && (fault_q != FAULT_MAX)) begin
      fault_d = fault_q + FAULT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rank_q  <= '0;
      fault_q <= '0;
    end else if (in_vld_q) begin
      if (last_q) begin
        // end of run: everything back to the empty state
        valid_q <= '0;
        rank_q  <= '0;
        fault_q <= '0;
      end else begin
        valid_q <= valid_d;
        rank_q  <= rank_d;
        fault_q <= fault_d;
      end
    end
  end

  // page store is only read behind a valid bit, so it needs no reset
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (in_vld_q && !pick.hit && sel[i]) begin
        frame_page_q[i] <= page_q;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result register, shown for exactly one cycle
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      res_hit_q     <= pick.hit;
      res_idx_q     <= FRAME_IDX_W'(idx);
      res_ev_q      <= pick.evict;
      res_ev_page_q <= pick.evict ? ev_page : '0;
      res_fault_q   <= fault_d;
    end
  end

  assign result_valid_o  = res_vld_q;
  assign hit_o           = res_hit_q;
  assign frame_index_o   = res_idx_q;
  assign evicted_valid_o = res_ev_q;
  assign evicted_page_o  = res_ev_page_q;
  assign fault_count_o   = res_fault_q;

endmodule

`default_nettype wire

@@ hw/rtl/lrupr_checker.sv @@
`default_nettype none

module lrupr_checker #(
  parameter int PAGE_BITS = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          result_valid_o,
  input logic                          hit_o,
  input logic                          evicted_valid_o,
  input logic [PAGE_BITS-1:0]          evicted_page_o,
  input logic [lrupr_pkg::FAULT_W-1:0] fault_count_o
);
  import lrupr_pkg::*;

  // every accepted reference produces a result after the input register and the result register
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 result_valid_o)
    else $error("accepted reference without result");

  // no result without an accepted reference
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, 2))
    else $error("result without accepted reference");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && hit_o) |-> !evicted_valid_o)
    else $error("eviction reported on a hit");

  a_evict_page_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !evicted_valid_o) |-> (evicted_page_o == '0))
    else $error("evicted page not zero without eviction");

  a_fault_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !hit_o) |-> (fault_count_o != '0))
    else $error("fault not counted");

endmodule

bind lru_page_replacement_top lrupr_checker #(
  .PAGE_BITS (PAGE_BITS)
) u_lrupr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .result_valid_o  (result_valid_o),
  .hit_o           (hit_o),
  .evicted_valid_o (evicted_valid_o),
  .evicted_page_o  (evicted_page_o),
  .fault_count_o   (fault_count_o)
);

`default_nettype wire
